@@ src/lpk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpk_pkg
// Shared types, constants and tables of the locally periodic kernel evaluator.
// ----------------------------------------------------------------------------
package lpk_pkg;

  localparam int unsigned DIM          = 4;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_USED  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int unsigned STEP_W       = 5;

  localparam int unsigned MUL_W  = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam logic signed [32:0] CORDIC_GAIN   = 33'sd652032874;
  localparam logic [30:0]        TWO_PI_Q28    = 31'd1686629713;
  localparam logic [30:0]        ONE_Q30       = 31'h4000_0000;
  localparam logic [3:0]         SERIES_TERMS  = 4'd14;

  typedef enum logic [1:0] {
    CFG_SIGMA = 2'd0,
    CFG_ILS   = 2'd1,
    CFG_IP    = 2'd2,
    CFG_MASK  = 2'd3
  } lpk_cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PHASE,
    ST_CSTART,
    ST_CWAIT,
    ST_SQ,
    ST_S1,
    ST_MAG,
    ST_QL,
    ST_QH,
    ST_QSUM,
    ST_EXP,
    ST_E_MUL,
    ST_E_RCP,
    ST_E_COR,
    ST_P_MUL,
    ST_P_UPD,
    ST_K_MUL,
    ST_K_UPD,
    ST_DEF,
    ST_END,
    ST_G_SEL,
    ST_G_SC,
    ST_G_W,
    ST_G_A,
    ST_G_KL,
    ST_G_LO,
    ST_G_HI,
    ST_G_OUT
  } lpk_state_e;

  typedef struct packed {
    logic              done;
    logic signed [32:0] sn;
    logic signed [32:0] cs;
  } lpk_trig_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // floor((2^32-1)/j); quotient estimate is at most one low
  function automatic logic [31:0] recip(input logic [3:0] j);
    logic [31:0] v;
    case (j)
      4'd1:    v = 32'd4294967295;
      4'd2:    v = 32'd2147483647;
      4'd3:    v = 32'd1431655765;
      4'd4:    v = 32'd1073741823;
      4'd5:    v = 32'd858993459;
      4'd6:    v = 32'd715827882;
      4'd7:    v = 32'd613566756;
      4'd8:    v = 32'd536870911;
      4'd9:    v = 32'd477218588;
      4'd10:   v = 32'd429496729;
      4'd11:   v = 32'd390451572;
      4'd12:   v = 32'd357913941;
      4'd13:   v = 32'd330382099;
      4'd14:   v = 32'd306783378;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ src/lpk_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpk_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lpk_mult import lpk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

@@ src/lpk_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpk_cordic
// Iterative CORDIC rotator, one step per cycle, giving sine and cosine in
// Q2.30 of an angle in units of 2^-32 turn.
// ----------------------------------------------------------------------------
module lpk_cordic import lpk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] angle_i,
  output lpk_trig_t   trig_o
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_USED - 1);

  logic                busy_q, done_q;
  logic [STEP_W-1:0]   step_q;
  logic signed [32:0]  x_q, y_q, z_q;
  logic [1:0]          quad_q;
  logic signed [32:0]  dx, dy, at;

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign at = {1'b0, atan_turn(step_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= {3'b000, angle_i[29:0]};
      quad_q <= angle_i[31:30];
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  always_comb begin
    trig_o.done = done_q;
    case (quad_q)
      2'd0: begin
        trig_o.sn = y_q;
        trig_o.cs = x_q;
      end
      2'd1: begin
        trig_o.sn = x_q;
        trig_o.cs = -y_q;
      end
      2'd2: begin
        trig_o.sn = -y_q;
        trig_o.cs = -x_q;
      end
      default: begin
        trig_o.sn = -x_q;
        trig_o.cs = y_q;
      end
    endcase
  end

endmodule

@@ src/locally_periodic_kernel_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locally_periodic_kernel_eval
// Locally periodic kernel value and per-dimension gradients in fixed point.
// ----------------------------------------------------------------------------
// Elements of tau enter one per transfer, and the block is busy until each one
// is done. An element of the first four dimensions takes, after its transfer,
// one product for the phase, a start and run of the 16-step CORDIC rotator,
// five multiplier passes and one state to update the sums. An element beyond
// that is only taken in its transfer, with no further work.
// The exponential follows the last element; a large exponent gives zero at once.
// Otherwise it takes a set-up state, then two 14-term series, each term two
// multiplier passes and a correction. Each whole unit of the exponent (at most
// 63 units) adds a multiply and an update, and the kernel value takes one more.
// Each requested gradient then takes a select state, the phase product, the
// CORDIC, six multiplier passes and a state to load the result. It takes
// longer while the result register is still held. A final state closes the run.
// The single 34x34 multiplier and the one CORDIC rotator set this sequence.
// A finished result waits in the output register while the next element is
// taken.
module locally_periodic_kernel_eval import lpk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] tau_element
  input  logic        s_axis_tlast_i,   // last_element
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] kernel_value, [63:32] gradient_value
  output logic [2:0]  m_axis_tuser_o,   // [1:0] dimension, [2] gradient_valid
  output logic        m_axis_tlast_o    // last_result
);

  localparam logic [2:0] DIM_C = 3'(DIM);

  lpk_state_e state_q, state_d;

  // configuration
  logic [31:0] sigma_q;
  logic [63:0] ils_q, ip_q;
  logic [3:0]  mask_q;

  // run state
  logic [31:0] s1_q, s2_q;
  logic [2:0]  cnt_q;
  logic [31:0] tau_store [4];

  // working registers
  logic [31:0]        tau_q;
  logic               last_q, grad_q, which_q;
  logic [1:0]         dim_q;
  logic [45:0]        q_q;
  logic [PROD_W-1:0]  acc_q;
  logic [5:0]         m_q;
  logic [16:0]        f_q;
  logic [30:0]        f30_q, r_q, t_q, e1_q, ex_q;
  logic [3:0]         j_q;
  logic [31:0]        kval_q;
  logic [3:0]         pend_q;
  logic [33:0]        sin2_q, inner_q;
  logic [35:0]        kl_q;

  // output register
  logic        out_valid_q;
  logic [31:0] out_kv_q, out_gv_q;
  logic [1:0]  out_dim_q;
  logic        out_gval_q, out_last_q;

  // shared units
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     trig_start;
  lpk_trig_t                trig;

  lpk_mult u_mult (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  lpk_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .angle_i ({mul_p[28:0], 3'b000}),
    .trig_o  (trig)
  );

  // datapath helpers
  logic [15:0] ils_cur, ip_cur;
  logic        in_xfer, out_free, out_load;
  logic [33:0] s2raw;
  logic [30:0] s2c;
  logic [31:0] tau_mag;
  logic [61:0] qtot;
  logic [49:0] t2w;
  logic [31:0] t2;
  logic [34:0] e35;
  logic [30:0] q0, qfix, rnext;
  logic [34:0] qj, rem;
  logic [29:0] aval;
  logic [33:0] inner_d, inner_neg;
  logic [32:0] imag;
  logic [69:0] gtot;
  logic [53:0] gmag;
  logic [31:0] gv;
  logic [3:0]  recv, pend_next, dim_bit;
  logic [1:0]  low_dim;

  assign ils_cur = ils_q[{dim_q, 4'b0000} +: 16];
  assign ip_cur  = ip_q[{dim_q, 4'b0000} +: 16];

  assign in_xfer  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~out_valid_q | m_axis_tready_i;

  assign s2raw   = mul_p[63:30];
  assign s2c     = (s2raw > {3'b000, ONE_Q30}) ? ONE_Q30 : s2raw[30:0];
  assign tau_mag = tau_q[31] ? (32'd0 - tau_q) : tau_q;

  assign qtot = {mul_p[29:0], 32'd0} + acc_q[61:0];
  assign t2w  = qtot[61:12];
  assign t2   = (|t2w[49:32]) ? 32'hFFFF_FFFF : t2w[31:0];

  assign e35 = {1'b0, s1_q, 2'b00} + {3'b000, s2_q};

  assign q0    = mul_p[62:32];
  assign qj    = {4'b0000, q0} * {31'd0, j_q};
  assign rem   = {4'b0000, t_q} - qj;
  assign qfix  = q0 + {30'd0, (rem >= {31'd0, j_q})};
  assign rnext = ONE_Q30 - qfix;

  assign aval      = mul_p[67:38];
  assign inner_d   = {{4{aval[29]}}, aval} + {{2{tau_q[31]}}, tau_q};
  assign inner_neg = 34'd0 - inner_q;
  assign imag      = inner_q[33] ? inner_neg[32:0] : inner_q[32:0];

  assign gtot = {4'b0000, acc_q[65:0]} + {mul_p[37:0], 32'd0};
  assign gmag = gtot[69:16];

  always_comb begin
    if (!inner_q[33] && (inner_q != 34'd0)) begin
      gv = (gmag > 54'h8000_0000) ? 32'h8000_0000 : (32'd0 - gmag[31:0]);
    end else begin
      gv = (gmag > 54'h7FFF_FFFF) ? 32'h7FFF_FFFF : gmag[31:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      recv[i] = (3'(i) < cnt_q) && (3'(i) < DIM_C);
    end
  end

  always_comb begin
    if (pend_q[0]) begin
      low_dim = 2'd0;
    end else if (pend_q[1]) begin
      low_dim = 2'd1;
    end else if (pend_q[2]) begin
      low_dim = 2'd2;
    end else begin
      low_dim = 2'd3;
    end
  end

  assign dim_bit   = 4'b0001 << dim_q;
  assign pend_next = pend_q & ~dim_bit;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cnt_q < DIM_C) begin
            state_d = ST_PHASE;
          end else if (s_axis_tlast_i) begin
            state_d = ST_EXP;
          end
        end
      end
      ST_PHASE:  state_d = ST_CSTART;
      ST_CSTART: state_d = ST_CWAIT;
      ST_CWAIT: begin
        if (trig.done) begin
          state_d = grad_q ? ST_G_SC : ST_SQ;
        end
      end
      ST_SQ:   state_d = ST_S1;
      ST_S1:   state_d = ST_MAG;
      ST_MAG:  state_d = ST_QL;
      ST_QL:   state_d = ST_QH;
      ST_QH:   state_d = ST_QSUM;
      ST_QSUM: state_d = last_q ? ST_EXP : ST_IDLE;
      ST_EXP:  state_d = (|e35[34:23]) ? ST_K_MUL : ST_E_MUL;
      ST_E_MUL: state_d = ST_E_RCP;
      ST_E_RCP: state_d = ST_E_COR;
      ST_E_COR: begin
        if (j_q == 4'd1 && which_q) begin
          state_d = ST_P_MUL;
        end else begin
          state_d = ST_E_MUL;
        end
      end
      ST_P_MUL: begin
        state_d = (m_q == 6'd0 || ex_q == 31'd0) ? ST_K_MUL : ST_P_UPD;
      end
      ST_P_UPD: state_d = ST_P_MUL;
      ST_K_MUL: state_d = ST_K_UPD;
      ST_K_UPD: state_d = ((mask_q & recv) != 4'd0) ? ST_G_SEL : ST_DEF;
      ST_DEF: begin
        if (out_free) begin
          state_d = ST_END;
        end
      end
      ST_END:   state_d = ST_IDLE;
      ST_G_SEL: state_d = ST_PHASE;
      ST_G_SC:  state_d = ST_G_W;
      ST_G_W:   state_d = ST_G_A;
      ST_G_A:   state_d = ST_G_KL;
      ST_G_KL:  state_d = ST_G_LO;
      ST_G_LO:  state_d = ST_G_HI;
      ST_G_HI:  state_d = ST_G_OUT;
      ST_G_OUT: begin
        if (out_free) begin
          state_d = (pend_next != 4'd0) ? ST_G_SEL : ST_END;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // unit control and handshakes
  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_en          = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    trig_start      = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_PHASE: begin
        mul_en = 1'b1;
        mul_a  = {{2{tau_q[31]}}, tau_q};
        mul_b  = {18'd0, ip_cur};
      end
      ST_CSTART: trig_start = 1'b1;
      ST_SQ: begin
        mul_en = 1'b1;
        mul_a  = {trig.sn[32], trig.sn};
        mul_b  = {trig.sn[32], trig.sn};
      end
      ST_S1: begin
        mul_en = 1'b1;
        mul_a  = {3'b000, s2c};
        mul_b  = {18'd0, ils_cur};
      end
      ST_MAG: begin
        mul_en = 1'b1;
        mul_a  = {2'b00, tau_mag};
        mul_b  = {2'b00, tau_mag};
      end
      ST_QL: begin
        mul_en = 1'b1;
        mul_a  = {2'b00, mul_p[47:16]};
        mul_b  = {18'd0, ils_cur};
      end
      ST_QH: begin
        mul_en = 1'b1;
        mul_a  = {20'd0, q_q[45:32]};
        mul_b  = {18'd0, ils_cur};
      end
      ST_E_MUL: begin
        mul_en = 1'b1;
        mul_a  = {3'b000, f30_q};
        mul_b  = {3'b000, r_q};
      end
      ST_E_RCP: begin
        mul_en = 1'b1;
        mul_a  = {3'b000, mul_p[60:30]};
        mul_b  = {2'b00, recip(j_q)};
      end
      ST_P_MUL: begin
        mul_en = 1'b1;
        mul_a  = {3'b000, ex_q};
        mul_b  = {3'b000, e1_q};
      end
      ST_K_MUL: begin
        mul_en = 1'b1;
        mul_a  = {2'b00, sigma_q};
        mul_b  = {3'b000, ex_q};
      end
      ST_DEF: out_load = out_free;
      ST_G_SC: begin
        mul_en = 1'b1;
        mul_a  = {trig.sn[32], trig.sn};
        mul_b  = {trig.cs[32], trig.cs};
      end
      ST_G_W: begin
        mul_en = 1'b1;
        mul_a  = {3'b000, TWO_PI_Q28};
        mul_b  = {18'd0, ip_cur};
      end
      ST_G_A: begin
        mul_en = 1'b1;
        mul_a  = {3'b000, mul_p[46:16]};
        mul_b  = sin2_q;
      end
      ST_G_KL: begin
        mul_en = 1'b1;
        mul_a  = {2'b00, kval_q};
        mul_b  = {18'd0, ils_cur};
      end
      ST_G_LO: begin
        mul_en = 1'b1;
        mul_a  = {2'b00, mul_p[43:12]};
        mul_b  = {1'b0, imag};
      end
      ST_G_HI: begin
        mul_en = 1'b1;
        mul_a  = {30'd0, kl_q[35:32]};
        mul_b  = {1'b0, imag};
      end
      ST_G_OUT: out_load = out_free;
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  // control state, configuration and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sigma_q     <= 32'd65536;
      ils_q       <= 64'h1000_1000_1000_1000;
      ip_q        <= 64'h1000_1000_1000_1000;
      mask_q      <= 4'd0;
      s1_q        <= '0;
      s2_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load | (out_valid_q & ~m_axis_tready_i);
      if (cfg_valid_i && cfg_ready_o) begin
        case (lpk_cfg_e'(cfg_index_i))
          CFG_SIGMA: sigma_q <= cfg_data_i[31:0];
          CFG_ILS:   ils_q   <= cfg_data_i;
          CFG_IP:    ip_q    <= cfg_data_i;
          CFG_MASK:  mask_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_MAG:  s1_q <= sat_add(s1_q, {11'd0, mul_p[46:26]});
        ST_QSUM: begin
          s2_q  <= sat_add(s2_q, t2);
          cnt_q <= cnt_q + 3'd1;
        end
        ST_END: begin
          s1_q  <= '0;
          s2_q  <= '0;
          cnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          tau_q  <= s_axis_tdata_i;
          last_q <= s_axis_tlast_i;
          dim_q  <= cnt_q[1:0];
          grad_q <= 1'b0;
        end
      end
      ST_QL:   q_q <= mul_p[61:16];
      ST_QH:   acc_q <= mul_p;
      ST_QSUM: tau_store[dim_q] <= tau_q;
      ST_EXP: begin
        m_q     <= e35[22:17];
        f_q     <= e35[16:0];
        which_q <= 1'b0;
        f30_q   <= ONE_Q30;
        r_q     <= ONE_Q30;
        j_q     <= SERIES_TERMS;
        if (|e35[34:23]) begin
          ex_q <= '0;
        end
      end
      ST_E_RCP: t_q <= mul_p[60:30];
      ST_E_COR: begin
        r_q <= rnext;
        j_q <= j_q - 4'd1;
        if (j_q == 4'd1) begin
          if (!which_q) begin
            e1_q    <= rnext;
            which_q <= 1'b1;
            f30_q   <= {1'b0, f_q, 13'd0};
            r_q     <= ONE_Q30;
            j_q     <= SERIES_TERMS;
          end else begin
            ex_q <= rnext;
          end
        end
      end
      ST_P_UPD: begin
        ex_q <= mul_p[60:30];
        m_q  <= m_q - 6'd1;
      end
      ST_K_UPD: begin
        kval_q <= mul_p[61:30];
        pend_q <= mask_q & recv;
      end
      ST_G_SEL: begin
        dim_q  <= low_dim;
        tau_q  <= tau_store[low_dim];
        grad_q <= 1'b1;
      end
      ST_G_W:  sin2_q <= mul_p[62:29];
      ST_G_KL: inner_q <= inner_d;
      ST_G_LO: kl_q <= mul_p[47:12];
      ST_G_HI: acc_q <= mul_p;
      ST_G_OUT: begin
        if (out_free) begin
          pend_q <= pend_next;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kv_q <= kval_q;
      if (state_q == ST_G_OUT) begin
        out_gv_q   <= gv;
        out_dim_q  <= dim_q;
        out_gval_q <= 1'b1;
        out_last_q <= (pend_next == 4'd0);
      end else begin
        out_gv_q   <= '0;
        out_dim_q  <= 2'd0;
        out_gval_q <= 1'b0;
        out_last_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_gv_q, out_kv_q};
  assign m_axis_tuser_o  = {out_gval_q, out_dim_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DIM_C)
    else $error("element count beyond DIM");

  a_trig_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig.done |-> state_q == ST_CWAIT)
    else $error("CORDIC finished outside its wait state");

  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_END |=> (cnt_q == 3'd0 && s1_q == 32'd0 && s2_q == 32'd0))
    else $error("run state not cleared at end of run");

  a_series_j: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_E_MUL || state_q == ST_E_RCP || state_q == ST_E_COR)
      |-> (j_q != 4'd0 && j_q <= SERIES_TERMS))
    else $error("series term index out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result register overwritten");
`endif

endmodule

@@ verif/locally_periodic_kernel_eval_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locally_periodic_kernel_eval_tb
// Streams tau vectors into the kernel evaluator under several register
// settings and idle patterns. A bit-exact fixed-point model predicts the
// kernel value and gradient transfers, checked in order at the output.
// ----------------------------------------------------------------------------
module locally_periodic_kernel_eval_tb;
  import lpk_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    int tau;
    bit last;
  } tau_item_t;

  typedef struct {
    logic [31:0] kval;
    logic [31:0] grad;
    logic [1:0]  dim;
    logic        gvalid;
    logic        last;
  } kernel_res_t;

  localparam int  CYCLE_LIMIT = 600000;
  localparam u64_t ONE30      = 64'd1 << 30;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // [31:0] tau_element
  logic        s_axis_tlast_i = 1'b0; // last_element
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;        // [31:0] kernel_value, [63:32] gradient_value
  logic [2:0]  m_axis_tuser_o;        // [1:0] dimension, [2] gradient_valid
  logic        m_axis_tlast_o;

  locally_periodic_kernel_eval uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] sigma_r;
  logic [63:0] ils_r;
  logic [63:0] ip_r;
  logic [3:0]  mask_r;
  logic [31:0] s1_acc;
  logic [31:0] s2_acc;
  int          elem_cnt;
  int          tau_hist [4];

  tau_item_t   tau_q [$];
  kernel_res_t kernel_q [$];
  int          n_errors = 0;
  int          cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          tx_hold = 1'b1;
  bit          in_fire = 1'b0;
  int          rx_hold_reqs = 0;
  int          rx_hold_served = 0;
  int          rx_hold_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic logic [31:0] sat32(input logic [31:0] a, input u64_t b);
    u64_t s;
    s = u64_t'(a) + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void cordic(input int tau, input u64_t ip,
                                 output longint sn, output longint cs);
    longint prod, x, y, z, dx, dy;
    logic [31:0] turn;
    prod = longint'(tau) * longint'(ip);
    turn = 32'(prod << 3);
    z = longint'({34'd0, turn[29:0]});
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_USED; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    case (turn[31:30])
      2'd0: begin sn = y;  cs = x;  end
      2'd1: begin sn = x;  cs = -y; end
      2'd2: begin sn = -y; cs = -x; end
      default: begin sn = -x; cs = y; end
    endcase
  endfunction

  function automatic u64_t exp_neg_frac(input u64_t f17);
    u64_t f30, r;
    f30 = f17 << 13;
    r = ONE30;
    for (int j = 14; j >= 1; j--) r = ONE30 - ((f30 * r) >> 30) / u64_t'(j);
    return r;
  endfunction

  function automatic void predict_kernel(input tau_item_t it);
    longint sn, cs, sin2, a, inner;
    u64_t ils, ip, s2, mag, t2, e17, m, ex, e1, kval, kl, imag, gmag, tp;
    kernel_res_t r;
    int n;
    n = 0;
    if (elem_cnt < DIM) begin
      ils = u64_t'(ils_r[16*elem_cnt +: 16]);
      ip  = u64_t'(ip_r[16*elem_cnt +: 16]);
      tau_hist[elem_cnt] = it.tau;
      cordic(it.tau, ip, sn, cs);
      s2 = u64_t'(sn * sn) >> 30;
      if (s2 > ONE30) s2 = ONE30;
      s1_acc = sat32(s1_acc, (s2 * ils) >> 26);
      mag = (it.tau < 0) ? u64_t'(-longint'(it.tau)) : u64_t'(longint'(it.tau));
      t2 = (((mag * mag) >> 16) * ils) >> 12;
      if (t2 > 64'hFFFF_FFFF) t2 = 64'hFFFF_FFFF;
      s2_acc = sat32(s2_acc, t2);
      elem_cnt++;
    end
    if (!it.last) return;
    e17 = 4 * u64_t'(s1_acc) + u64_t'(s2_acc);
    m = e17 >> 17;
    if (m >= 64) ex = 0;
    else begin
      ex = exp_neg_frac(e17 & 64'h1FFFF);
      e1 = exp_neg_frac(64'd1 << 17);
      while (m > 0 && ex != 0) begin
        ex = (ex * e1) >> 30;
        m--;
      end
    end
    kval = (u64_t'(sigma_r) * ex) >> 30;
    for (int d = 0; d < DIM; d++) begin
      if (mask_r[d] && d < elem_cnt) begin
        ils = u64_t'(ils_r[16*d +: 16]);
        ip  = u64_t'(ip_r[16*d +: 16]);
        cordic(tau_hist[d], ip, sn, cs);
        sin2 = (2 * sn * cs) >>> 30;
        tp = (u64_t'(TWO_PI_Q28) * ip) >> 16;
        a = (longint'(tp) * sin2) >>> 38;
        inner = a + longint'(tau_hist[d]);
        kl = (kval * ils) >> 12;
        imag = (inner < 0) ? u64_t'(-inner) : u64_t'(inner);
        if (kl != 0 && imag > 64'hFFFF_FFFF_FFFF_FFFF / kl) gmag = 64'hFFFF_FFFF_FFFF_FFFF;
        else gmag = (kl * imag) >> 16;
        if (inner > 0) begin
          if (gmag > 64'h8000_0000) gmag = 64'h8000_0000;
          r.grad = 32'(-gmag);
        end else begin
          if (gmag > 64'h7FFF_FFFF) gmag = 64'h7FFF_FFFF;
          r.grad = gmag[31:0];
        end
        r.kval = kval[31:0];
        r.dim = 2'(d);
        r.gvalid = 1'b1;
        r.last = 1'b0;
        kernel_q.push_back(r);
        n++;
      end
    end
    if (n == 0) begin
      r.kval = kval[31:0];
      r.grad = '0;
      r.dim = '0;
      r.gvalid = 1'b0;
      r.last = 1'b0;
      kernel_q.push_back(r);
    end
    kernel_q[kernel_q.size()-1].last = 1'b1;
    s1_acc = '0;
    s2_acc = '0;
    elem_cnt = 0;
  endfunction

  // input side: acceptance and prediction
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      predict_kernel('{tau: int'(s_axis_tdata_i), last: s_axis_tlast_i});
      in_fire = 1'b1;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid_i || in_fire) begin
      if (!tx_hold && tau_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tdata_i  <= tau_q[0].tau;
        s_axis_tlast_i  <= tau_q[0].last;
        s_axis_tvalid_i <= 1'b1;
        void'(tau_q.pop_front());
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    in_fire = 1'b0;
  end

  // long receiver hold-off
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) rx_hold_left <= rx_hold_left - 1;
    else if (rx_hold_reqs != rx_hold_served) begin
      rx_hold_left <= 400;
      rx_hold_served <= rx_hold_reqs;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && rx_hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
  end

  // monitor
  always @(posedge clk_i) begin
    kernel_res_t e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (kernel_q.size() == 0) begin
        $display("[%0t] unexpected result transfer %h", $realtime, m_axis_tdata_o);
        n_errors++;
      end else begin
        e = kernel_q.pop_front();
        if (m_axis_tdata_o[31:0] !== e.kval)
          report_mismatch("kernel_value", m_axis_tdata_o[31:0], e.kval);
        if (m_axis_tdata_o[63:32] !== e.grad)
          report_mismatch("gradient_value", m_axis_tdata_o[63:32], e.grad);
        if (m_axis_tuser_o[1:0] !== e.dim)
          report_mismatch("dimension", 32'(m_axis_tuser_o[1:0]), 32'(e.dim));
        if (m_axis_tuser_o[2] !== e.gvalid)
          report_mismatch("gradient_valid", 32'(m_axis_tuser_o[2]), 32'(e.gvalid));
        if (m_axis_tlast_o !== e.last)
          report_mismatch("last_result", 32'(m_axis_tlast_o), 32'(e.last));
      end
    end
  end

  task automatic cfg_write(input lpk_cfg_e idx, input logic [63:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SIGMA: sigma_r = v[31:0];
      CFG_ILS:   ils_r = v;
      CFG_IP:    ip_r = v;
      CFG_MASK:  mask_r = v[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] sg, input logic [63:0] ls, input logic [63:0] pr,
                          input logic [63:0] mk);
    cfg_write(CFG_SIGMA, {32'd0, sg});
    cfg_write(CFG_ILS, ls);
    cfg_write(CFG_IP, pr);
    cfg_write(CFG_MASK, mk);
  endtask

  task automatic drain();
    tx_hold = 1'b0;
    do @(posedge clk_i); while (tau_q.size() > 0 || s_axis_tvalid_i || kernel_q.size() > 0);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic int rand_tau(input bit wide);
    if (wide) return int'($urandom);
    return int'($urandom_range(0, 32'h40000)) - 32'h20000;
  endfunction

  task automatic add_run(input int len, input bit wide);
    for (int i = 0; i < len; i++)
      tau_q.push_back('{tau: rand_tau(wide && $urandom_range(1)), last: (i == len - 1)});
  endtask

  task automatic add_fixed(input int vals [$]);
    foreach (vals[i]) tau_q.push_back('{tau: vals[i], last: (i == vals.size() - 1)});
  endtask

  function automatic logic [63:0] rand_fields(input int hi);
    logic [63:0] v;
    for (int d = 0; d < 4; d++) v[16*d +: 16] = 16'($urandom_range(0, hi));
    return v;
  endfunction

  initial begin
    sigma_r = 32'd65536;
    ils_r = 64'h1000_1000_1000_1000;
    ip_r = 64'h1000_1000_1000_1000;
    mask_r = '0;
    s1_acc = '0;
    s2_acc = '0;
    elem_cnt = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: register defaults, then extremes
    add_fixed('{0});
    add_fixed('{1, -1, 32'h7FFF_FFFF, 32'h8000_0000});
    add_fixed('{32'h8000, -32'h8000, 32'h10000, 5, 7, 9});
    drain();
    set_regs(32'h0002_0000, 64'h1000_1000_1000_1000, 64'h1000_1000_1000_1000, 64'hF);
    add_fixed('{32'h4000, -32'h6000, 32'h2000, 32'h800});
    add_fixed('{32'h3000, 32'h1000});
    drain();
    set_regs(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hF);
    add_fixed('{1, 32'h100, -1, 32'h80});
    drain();
    set_regs(32'h0, 64'h0, 64'h0, 64'h5);
    add_fixed('{32'h7FFF_FFFF, 32'h8000_0000, 0});
    drain();
    set_regs(32'hFFFF_FFFF, 64'h0, 64'h0, 64'hF);
    add_fixed('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, -32'h1234_5678});
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      set_regs($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(32'h8000, 32'h40_0000),
               rand_fields(p == 7 ? 16'hFFFF : 16'h1800), rand_fields(16'hFFFF),
               64'($urandom_range(0, 15)));
      if (p == 2) rx_hold_reqs++;
      for (int r = 0; r < 10; r++) add_run($urandom_range(1, r == 0 ? 6 : 4), p >= 6);
      drain();
    end

    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
